// ===== hw/rtl/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Shared widths, codes, melody tables and the control program of the tone
// melody / sweep sequencer.
// ----------------------------------------------------------------------------
package tms_pkg;

   localparam int NUM_MELODIES   = 6;
   localparam int MAX_NOTES      = 12;
   localparam int TONE_NUMERATOR = 31250;

   localparam int MODE_W     = 2;
   localparam int SEL_W      = 3;
   localparam int TICKS_W    = 10;
   localparam int HOLD_W     = 8;
   localparam int START_W    = 10;
   localparam int FREQ_W     = 11;
   localparam int POS_W      = 4;
   localparam int LEN_W      = 5;
   localparam int CMP_W      = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam int PC_W       = 3;

   localparam logic [MODE_W-1:0] MODE_BOOT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd3;

   localparam logic [MODE_W-1:0] REQ_PLAY  = 2'd1;
   localparam logic [MODE_W-1:0] REQ_SWEEP = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_NOTE_HOLD   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SWEEP_START = 1'd1;

   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd16;
   localparam logic [START_W-1:0] START_RESET = 10'd250;
   localparam logic [FREQ_W-1:0]  FREQ_RESET  = 11'd250;

   localparam logic [LEN_W-1:0] MELODY_LEN [8] = '{
      5'd12, 5'd2, 5'd3, 5'd3, 5'd3, 5'd8, 5'd0, 5'd0
   };

   localparam logic [FREQ_W-1:0] MELODY_ROM [8][16] = '{
      '{11'd261, 11'd261, 11'd523, 11'd440, 11'd392, 11'd329, 11'd392, 11'd392,
        11'd392, 11'd293, 11'd293, 11'd293, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd523, 11'd523, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd200, 11'd200, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd320, 11'd180, 11'd180, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd261, 11'd523, 11'd523, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd261, 11'd329, 11'd392, 11'd523, 11'd523, 11'd392, 11'd523, 11'd523,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
      '{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}
   };

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_ACCEPT    = 3'd1,
      OP_MODE      = 3'd2,
      OP_ACT       = 3'd3,
      OP_LOAD_TONE = 3'd4,
      OP_EMIT      = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_INPUT = 3'd2,
      COND_NO_TONE  = 3'd3,
      COND_DIV_BUSY = 3'd4,
      COND_OUT_FULL = 3'd5
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic no_input;
      logic no_tone;
      logic div_busy;
      logic out_full;
   } status_type;

   localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [PC_W-1:0] STEP_MODE   = 3'd1;
   localparam logic [PC_W-1:0] STEP_ACT    = 3'd2;
   localparam logic [PC_W-1:0] STEP_DIV    = 3'd3;
   localparam logic [PC_W-1:0] STEP_SAT    = 3'd4;
   localparam logic [PC_W-1:0] STEP_EMIT   = 3'd5;
   localparam logic [PC_W-1:0] STEP_RETURN = 3'd6;

   // Control store: a jump is taken when its condition holds, else fall through.
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      unique case (pc)
         STEP_IDLE:   cw = '{OP_ACCEPT,    COND_NO_INPUT, STEP_IDLE};
         STEP_MODE:   cw = '{OP_MODE,      COND_NEVER,    STEP_IDLE};
         STEP_ACT:    cw = '{OP_ACT,       COND_NO_TONE,  STEP_EMIT};
         STEP_DIV:    cw = '{OP_NONE,      COND_DIV_BUSY, STEP_DIV};
         STEP_SAT:    cw = '{OP_LOAD_TONE, COND_NEVER,    STEP_IDLE};
         STEP_EMIT:   cw = '{OP_EMIT,      COND_OUT_FULL, STEP_EMIT};
         STEP_RETURN: cw = '{OP_NONE,      COND_ALWAYS,   STEP_IDLE};
         default:     cw = '{OP_NONE,      COND_ALWAYS,   STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== hw/rtl/tms_divider.sv =====
// ----------------------------------------------------------------------------
// tms_divider
// Bit-serial restoring divider: fixed numerator over a frequency divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tms_divider #(
   parameter int TONE_NUMERATOR = tms_pkg::TONE_NUMERATOR
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [tms_pkg::FREQ_W-1:0]                divisor,
   output logic                                      busy,
   output logic [$clog2(TONE_NUMERATOR+1)-1:0]      quotient
);

   localparam int NUM_W = $clog2(TONE_NUMERATOR + 1);
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int FW    = tms_pkg::FREQ_W;
   localparam logic [NUM_W-1:0] DIVIDEND = NUM_W'(TONE_NUMERATOR);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] shift_ff, shift_in;
   logic [FW-1:0]    rem_ff, rem_in;
   logic [FW-1:0]    div_ff, div_in;
   logic [FW:0]      trial;
   logic [FW:0]      diff;
   logic             fits;

   assign trial = {rem_ff, shift_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         cnt_in   = CNT_W'(NUM_W);
         shift_in = DIVIDEND;
         rem_in   = '0;
         div_in   = divisor;
      end else if (cnt_ff != '0) begin
         // shift the next dividend bit into the remainder, quotient bit in at the bottom
         cnt_in   = cnt_ff - CNT_W'(1);
         shift_in = {shift_ff[NUM_W-2:0], fits};
         rem_in   = fits ? diff[FW-1:0] : trial[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = shift_ff;

endmodule

// ===== hw/rtl/tms_sequencer.sv =====
// ----------------------------------------------------------------------------
// tms_sequencer
// Step counter over the control store; issues one datapath op per cycle and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module tms_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  tms_pkg::status_type status,
   output tms_pkg::op_type     op
);

   logic [tms_pkg::PC_W-1:0] pc_ff, pc_in;
   tms_pkg::ctrl_word_type   cw;
   logic                     take;

   assign cw = tms_pkg::ucode(pc_ff);

   always_comb begin
      unique case (cw.cond)
         tms_pkg::COND_NEVER:    take = 1'b0;
         tms_pkg::COND_ALWAYS:   take = 1'b1;
         tms_pkg::COND_NO_INPUT: take = status.no_input;
         tms_pkg::COND_NO_TONE:  take = status.no_tone;
         tms_pkg::COND_DIV_BUSY: take = status.div_busy;
         tms_pkg::COND_OUT_FULL: take = status.out_full;
         default:                take = 1'b1;
      endcase
      pc_in = take ? cw.target : pc_ff + tms_pkg::PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tms_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = cw.op;

endmodule

// ===== hw/rtl/tone_melody_sweep_sequencer_core.sv =====
// A tick is accepted, the mode step runs, then the act step; a tick that loads
// a tone waits on the bit-serial divider, one quotient bit per cycle, then loads
// the saturated quotient; every tick ends by emitting its word, which stalls while
// the output is full. A new tick is accepted only after the last one is emitted.
// Reset: synchronous, clears mode to boot, state and config to defaults.
// ----------------------------------------------------------------------------
// tone_melody_sweep_sequencer_core
// Melody / frequency sweep tone sequencer: one tone compare word per tick,
// datapath driven by a microcoded step sequencer.
// ----------------------------------------------------------------------------
module tone_melody_sweep_sequencer_core #(
   parameter int TONE_NUMERATOR = tms_pkg::TONE_NUMERATOR
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [1:0] mode_request, [4:2] melody_select, [14:5] sweep_ticks
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tms_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: [7:0] tone_compare, [9:8] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tms_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tms_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int QUOT_W = $clog2(TONE_NUMERATOR + 1);

   tms_pkg::op_type     seq_op;
   tms_pkg::status_type status;

   logic [tms_pkg::HOLD_W-1:0]  hold_ff, hold_in;
   logic [tms_pkg::START_W-1:0] start_freq_ff, start_freq_in;

   logic [tms_pkg::MODE_W-1:0]  req_mode_ff, req_mode_in;
   logic [tms_pkg::SEL_W-1:0]   req_sel_ff, req_sel_in;
   logic [tms_pkg::TICKS_W-1:0] req_ticks_ff, req_ticks_in;

   logic [tms_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [tms_pkg::SEL_W-1:0]   melody_ff, melody_in;
   logic [tms_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [tms_pkg::TICKS_W-1:0] tick_ff, tick_in;
   logic [tms_pkg::FREQ_W-1:0]  sweep_freq_ff, sweep_freq_in;
   logic [tms_pkg::CMP_W-1:0]   compare_ff, compare_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tms_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [tms_pkg::LEN_W-1:0]   len_raw;
   logic [tms_pkg::LEN_W-1:0]   notes;
   logic                        notes_left;
   logic                        hold_more;
   logic                        sweep_active;
   logic                        play_load;
   logic                        act_tone;
   logic [tms_pkg::FREQ_W-1:0]  note_freq;
   logic [tms_pkg::FREQ_W-1:0]  tone_freq;
   logic [tms_pkg::TICKS_W-1:0] tick_inc;
   logic                        req_fire;
   logic                        out_full;
   logic                        div_start;
   logic                        div_busy;
   logic [QUOT_W-1:0]           quotient;
   logic [QUOT_W-1:0]           quot_m1;
   logic [tms_pkg::CMP_W-1:0]   tone_sat;

   tms_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (seq_op)
   );

   tms_divider #(
      .TONE_NUMERATOR (TONE_NUMERATOR)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (tone_freq),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign req_tready = seq_op == tms_pkg::OP_ACCEPT;
   assign req_fire   = req_tvalid && req_tready;
   assign out_full   = rsp_valid_ff && !rsp_tready;

   // melody length: nothing beyond the table, capped at the note limit
   assign len_raw = tms_pkg::MELODY_LEN[melody_ff];
   always_comb begin
      if (int'(melody_ff) >= tms_pkg::NUM_MELODIES) begin
         notes = '0;
      end else if (int'(len_raw) > tms_pkg::MAX_NOTES) begin
         notes = tms_pkg::LEN_W'(tms_pkg::MAX_NOTES);
      end else begin
         notes = len_raw;
      end
   end

   assign notes_left   = {1'b0, pos_ff} < notes;
   assign hold_more    = tick_ff < {2'b00, hold_ff};
   assign note_freq    = tms_pkg::MELODY_ROM[melody_ff][pos_ff];
   assign play_load    = (mode_ff == tms_pkg::MODE_PLAY) && notes_left && !hold_more;
   assign sweep_active = (mode_ff == tms_pkg::MODE_SWEEP) && (tick_ff < req_ticks_ff);
   assign tone_freq    = (mode_ff == tms_pkg::MODE_PLAY) ? note_freq : sweep_freq_ff;
   assign act_tone     = (play_load || sweep_active) && (tone_freq != '0);
   assign tick_inc     = tick_ff + tms_pkg::TICKS_W'(1);
   assign div_start    = (seq_op == tms_pkg::OP_ACT) && act_tone;

   assign quot_m1 = quotient - QUOT_W'(1);
   always_comb begin
      if (quotient == '0) begin
         tone_sat = '0;
      end else if (quot_m1 > QUOT_W'(255)) begin
         tone_sat = '1;
      end else begin
         tone_sat = quot_m1[tms_pkg::CMP_W-1:0];
      end
   end

   assign status = '{
      no_input: !req_tvalid,
      no_tone:  !act_tone,
      div_busy: div_busy,
      out_full: out_full
   };

   always_comb begin
      hold_in       = hold_ff;
      start_freq_in = start_freq_ff;
      req_mode_in   = req_mode_ff;
      req_sel_in    = req_sel_ff;
      req_ticks_in  = req_ticks_ff;
      mode_in       = mode_ff;
      melody_in     = melody_ff;
      pos_in        = pos_ff;
      tick_in       = tick_ff;
      sweep_freq_in = sweep_freq_ff;
      compare_in    = compare_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         if (csr_addr == tms_pkg::CSR_NOTE_HOLD) begin
            hold_in = csr_wdata[tms_pkg::HOLD_W-1:0];
         end
         if (csr_addr == tms_pkg::CSR_SWEEP_START) begin
            start_freq_in = csr_wdata[tms_pkg::START_W-1:0];
         end
      end

      unique case (seq_op)
         tms_pkg::OP_ACCEPT: begin
            if (req_tvalid) begin
               req_mode_in  = req_tdata[1:0];
               req_sel_in   = req_tdata[4:2];
               req_ticks_in = req_tdata[14:5];
            end
         end
         tms_pkg::OP_MODE: begin
            unique case (mode_ff)
               tms_pkg::MODE_BOOT: mode_in = tms_pkg::MODE_WAIT;
               tms_pkg::MODE_WAIT: begin
                  if (req_mode_ff == tms_pkg::REQ_PLAY) begin
                     melody_in = req_sel_ff;
                     tick_in   = '0;
                     pos_in    = '0;
                     mode_in   = tms_pkg::MODE_PLAY;
                  end else if (req_mode_ff == tms_pkg::REQ_SWEEP) begin
                     tick_in       = '0;
                     sweep_freq_in = {1'b0, start_freq_ff};
                     mode_in       = tms_pkg::MODE_SWEEP;
                  end
               end
               tms_pkg::MODE_PLAY: begin
                  if (!notes_left) begin
                     compare_in = '0;
                     if (req_mode_ff == tms_pkg::REQ_PLAY) begin
                        mode_in = tms_pkg::MODE_PLAY;
                     end else if (req_mode_ff == tms_pkg::REQ_SWEEP) begin
                        mode_in = tms_pkg::MODE_SWEEP;
                     end else begin
                        mode_in = tms_pkg::MODE_WAIT;
                     end
                  end
               end
               tms_pkg::MODE_SWEEP: begin
                  if (tick_ff >= req_ticks_ff) begin
                     compare_in = '0;
                     tick_in    = '0;
                     pos_in     = '0;
                     mode_in    = tms_pkg::MODE_PLAY;
                  end
               end
               default: mode_in = mode_ff;
            endcase
         end
         tms_pkg::OP_ACT: begin
            if (mode_ff == tms_pkg::MODE_PLAY) begin
               if (!notes_left) begin
                  compare_in = '0;
               end else if (hold_more) begin
                  tick_in = tick_inc;
               end else begin
                  tick_in = '0;
                  pos_in  = pos_ff + tms_pkg::POS_W'(1);
                  if (tone_freq == '0) begin
                     compare_in = '0;
                  end
               end
            end else if (sweep_active) begin
               tick_in = tick_inc;
               if (tone_freq == '0) begin
                  compare_in = '0;
               end
               // rise during the first half of the sweep, fall afterwards
               if (tick_inc < (req_ticks_ff >> 1)) begin
                  sweep_freq_in = sweep_freq_ff + tms_pkg::FREQ_W'(1);
               end else begin
                  sweep_freq_in = sweep_freq_ff - tms_pkg::FREQ_W'(1);
               end
            end
         end
         tms_pkg::OP_LOAD_TONE: compare_in = tone_sat;
         tms_pkg::OP_EMIT: begin
            if (!out_full) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(tms_pkg::RSP_DATA_W - tms_pkg::MODE_W - tms_pkg::CMP_W)'(0),
                               mode_ff, compare_ff};
            end
         end
         tms_pkg::OP_NONE: compare_in = compare_ff;
         default: compare_in = compare_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff       <= tms_pkg::HOLD_RESET;
         start_freq_ff <= tms_pkg::START_RESET;
         mode_ff       <= tms_pkg::MODE_BOOT;
         melody_ff     <= '0;
         pos_ff        <= '0;
         tick_ff       <= '0;
         sweep_freq_ff <= tms_pkg::FREQ_RESET;
         compare_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_ff       <= hold_in;
         start_freq_ff <= start_freq_in;
         mode_ff       <= mode_in;
         melody_ff     <= melody_in;
         pos_ff        <= pos_in;
         tick_ff       <= tick_in;
         sweep_freq_ff <= sweep_freq_in;
         compare_ff    <= compare_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_mode_ff  <= req_mode_in;
      req_sel_ff   <= req_sel_in;
      req_ticks_ff <= req_ticks_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_accept_then_mode: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (seq_op == tms_pkg::OP_MODE))
      else $error("accepted word not followed by mode step");

   a_tone_after_div: assert property (@(posedge clock) disable iff (reset)
      (seq_op == tms_pkg::OP_LOAD_TONE) |-> !div_busy)
      else $error("tone loaded while divider still running");

   a_mode_leaves_boot: assert property (@(posedge clock) disable iff (reset)
      (seq_op == tms_pkg::OP_MODE) |=> (mode_ff != tms_pkg::MODE_BOOT))
      else $error("mode step left the block in boot");

   a_wait_silent: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == tms_pkg::MODE_WAIT) |-> (compare_ff == '0))
      else $error("tone compare not silent in wait");

   a_rsp_mode: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_data_ff[9:8] == mode_ff))
      else $error("result word mode differs from mode register");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Tick-level check of the tone melody / sweep sequencer: every accepted tick
// word runs through a local copy of the mode machine, and each response word
// is compared field by field with the oldest predicted tone and mode.
// ----------------------------------------------------------------------------
module tb_top;

   // request codes that the package leaves unnamed
   localparam logic [tms_pkg::MODE_W-1:0] REQ_IDLE  = 2'd0;
   localparam logic [tms_pkg::MODE_W-1:0] REQ_SPARE = 2'd3;

   typedef struct packed {
      logic [tms_pkg::CMP_W-1:0]  tone;
      logic [tms_pkg::MODE_W-1:0] mode;
   } tone_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // [1:0] mode_request, [4:2] melody_select, [14:5] sweep_ticks
   logic [tms_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // [7:0] tone_compare, [9:8] mode
   logic [tms_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                               csr_we = 1'b0;
   logic [tms_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [tms_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   // local melody table
   int tune_len [6] = '{12, 2, 3, 3, 3, 8};
   int tune_freq [6][12] = '{
      '{261, 261, 523, 440, 392, 329, 392, 392, 392, 293, 293, 293},
      '{523, 523, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{200, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{320, 180, 180, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{261, 523, 523, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{261, 329, 392, 523, 523, 392, 523, 523, 0, 0, 0, 0}
   };

   // predicted sequencer state and configuration
   logic [tms_pkg::MODE_W-1:0]  seq_mode  = tms_pkg::MODE_BOOT;
   logic [tms_pkg::SEL_W-1:0]   tune_sel  = '0;
   logic [tms_pkg::POS_W-1:0]   note_pos  = '0;
   logic [tms_pkg::TICKS_W-1:0] tick_cnt  = '0;
   logic [tms_pkg::FREQ_W-1:0]  sweep_hz  = tms_pkg::FREQ_RESET;
   logic [tms_pkg::CMP_W-1:0]   tone_cmp  = '0;
   logic [tms_pkg::HOLD_W-1:0]  hold_cfg  = tms_pkg::HOLD_RESET;
   logic [tms_pkg::START_W-1:0] start_cfg = tms_pkg::START_RESET;

   tone_word_type               tone_words_due [$];
   int                          mismatch_count = 0;
   int                          send_idle_pct = 0;
   int                          rsp_idle_pct = 0;
   int                          rsp_stall_cycles = 0;
   logic [tms_pkg::TICKS_W-1:0] sweep_plan = '0;

   tone_melody_sweep_sequencer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [tms_pkg::CMP_W-1:0] tone_of_hz(input int hz);
      int q;
      if (hz == 0) return '0;
      q = tms_pkg::TONE_NUMERATOR / hz;
      if (q == 0) return '0;
      q = q - 1;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic int notes_of(input logic [tms_pkg::SEL_W-1:0] m);
      if (int'(m) >= tms_pkg::NUM_MELODIES) return 0;
      return (tune_len[m] > tms_pkg::MAX_NOTES) ? tms_pkg::MAX_NOTES : tune_len[m];
   endfunction

   // Advance the predicted machine by one tick and return the word it emits.
   function automatic tone_word_type next_tone_word(
         input logic [tms_pkg::MODE_W-1:0]  req,
         input logic [tms_pkg::SEL_W-1:0]   sel,
         input logic [tms_pkg::TICKS_W-1:0] span);
      tone_word_type w;
      int            notes;
      case (seq_mode)
         tms_pkg::MODE_BOOT: seq_mode = tms_pkg::MODE_WAIT;
         tms_pkg::MODE_WAIT: begin
            if (req == tms_pkg::REQ_PLAY) begin
               tune_sel = sel;
               tick_cnt = '0;
               note_pos = '0;
               seq_mode = tms_pkg::MODE_PLAY;
            end else if (req == tms_pkg::REQ_SWEEP) begin
               tick_cnt = '0;
               sweep_hz = {1'b0, start_cfg};
               seq_mode = tms_pkg::MODE_SWEEP;
            end
         end
         tms_pkg::MODE_PLAY: begin
            if (int'(note_pos) >= notes_of(tune_sel)) begin
               tone_cmp = '0;
               seq_mode = (req == tms_pkg::REQ_PLAY) ? tms_pkg::MODE_PLAY :
                          (req == tms_pkg::REQ_SWEEP) ? tms_pkg::MODE_SWEEP :
                          tms_pkg::MODE_WAIT;
            end
         end
         default: begin
            if (tick_cnt >= span) begin
               tone_cmp = '0;
               tick_cnt = '0;
               note_pos = '0;
               seq_mode = tms_pkg::MODE_PLAY;
            end
         end
      endcase

      if (seq_mode == tms_pkg::MODE_PLAY) begin
         notes = notes_of(tune_sel);
         if (int'(note_pos) < notes) begin
            if (tick_cnt < {2'b00, hold_cfg}) begin
               tick_cnt = tick_cnt + 1'b1;
            end else begin
               tick_cnt = '0;
               tone_cmp = tone_of_hz(tune_freq[tune_sel][note_pos]);
               note_pos = note_pos + 1'b1;
            end
         end else begin
            tone_cmp = '0;
         end
      end else if (seq_mode == tms_pkg::MODE_SWEEP) begin
         if (tick_cnt < span) begin
            tick_cnt = tick_cnt + 1'b1;
            tone_cmp = tone_of_hz(int'(sweep_hz));
            if (tick_cnt < (span >> 1)) sweep_hz = sweep_hz + 1'b1;
            else sweep_hz = sweep_hz - 1'b1;
         end
      end

      w.tone = tone_cmp;
      w.mode = seq_mode;
      return w;
   endfunction

   function automatic logic [tms_pkg::TICKS_W-1:0] pick_span();
      int roll;
      roll = $urandom_range(99);
      if (roll < 90) return tms_pkg::TICKS_W'($urandom_range(24));
      if (roll < 99) return tms_pkg::TICKS_W'($urandom_range(120, 25));
      return tms_pkg::TICKS_W'($urandom_range(1023, 900));
   endfunction

   task automatic flag_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   // Offer one tick word, hold it until accepted, then predict its response.
   task automatic send_tick(input logic [tms_pkg::MODE_W-1:0]  req,
                            input logic [tms_pkg::SEL_W-1:0]   sel,
                            input logic [tms_pkg::TICKS_W-1:0] span);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, span, sel, req};
      do @(posedge clock); while (!req_tready);
      tone_words_due.push_back(next_tone_word(req, sel, span));
   endtask

   // Drop valid, wait for every predicted word, then let the block settle.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (tone_words_due.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tms_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [tms_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == tms_pkg::CSR_NOTE_HOLD) hold_cfg = data[tms_pkg::HOLD_W-1:0];
      else start_cfg = data[tms_pkg::START_W-1:0];
      @(posedge clock);
   endtask

   // Choose fields from the predicted mode so most ticks form whole melodies
   // and sweeps; the rest are random noise.
   task automatic random_tick();
      logic [tms_pkg::MODE_W-1:0]  req;
      logic [tms_pkg::SEL_W-1:0]   sel;
      logic [tms_pkg::TICKS_W-1:0] span;
      int                          roll;
      req  = tms_pkg::MODE_W'($urandom_range(3));
      sel  = tms_pkg::SEL_W'($urandom_range(7));
      span = tms_pkg::TICKS_W'($urandom_range(1023));
      roll = $urandom_range(99);
      if (seq_mode == tms_pkg::MODE_WAIT) begin
         if (roll < 45) begin
            req = tms_pkg::REQ_PLAY;
            if ($urandom_range(9) != 0)
               sel = tms_pkg::SEL_W'($urandom_range(tms_pkg::NUM_MELODIES - 1));
         end else if (roll < 80) begin
            req = tms_pkg::REQ_SWEEP;
            sweep_plan = pick_span();
            span = sweep_plan;
         end else begin
            req = $urandom_range(1) ? REQ_IDLE : REQ_SPARE;
         end
      end else if (seq_mode == tms_pkg::MODE_PLAY &&
                   int'(note_pos) >= notes_of(tune_sel)) begin
         // melody over: the request picks the next mode
         if (roll < 50) begin
            req = tms_pkg::REQ_SWEEP;
            sweep_plan = pick_span();
            span = sweep_plan;
         end else if (roll < 80) begin
            req = $urandom_range(1) ? REQ_IDLE : REQ_SPARE;
         end else begin
            req = tms_pkg::REQ_PLAY;
         end
      end else if (seq_mode == tms_pkg::MODE_SWEEP) begin
         if (roll < 92) span = sweep_plan;
      end
      send_tick(req, sel, span);
   endtask

   task automatic test_wait_codes();
      send_tick(REQ_IDLE, 3'd0, 10'd0);
      send_tick(REQ_SPARE, 3'd7, 10'd1023);
      send_tick(REQ_IDLE, 3'd5, 10'd512);
   endtask

   task automatic test_melody_end();
      drain_block();
      write_reg(tms_pkg::CSR_NOTE_HOLD, 10'h300);
      send_tick(tms_pkg::REQ_PLAY, 3'd2, 10'd0);
      send_tick(tms_pkg::REQ_PLAY, 3'd0, 10'd0);
      send_tick(tms_pkg::REQ_PLAY, 3'd0, 10'd0);
      // replay at melody end stays silent until the request changes
      send_tick(tms_pkg::REQ_PLAY, 3'd1, 10'd0);
      send_tick(tms_pkg::REQ_PLAY, 3'd1, 10'd0);
      send_tick(REQ_SPARE, 3'd0, 10'd0);
   endtask

   task automatic test_sweep_after_silence();
      send_tick(tms_pkg::REQ_PLAY, 3'd7, 10'd0);
      // sweep entered from a finished melody keeps counter and frequency
      send_tick(tms_pkg::REQ_SWEEP, 3'd0, 10'd3);
      send_tick(REQ_IDLE, 3'd0, 10'd3);
      send_tick(REQ_IDLE, 3'd0, 10'd3);
      send_tick(REQ_IDLE, 3'd0, 10'd3);
      send_tick(REQ_IDLE, 3'd0, 10'd3);
   endtask

   task automatic test_freq_wrap();
      drain_block();
      write_reg(tms_pkg::CSR_SWEEP_START, 10'd1);
      // falls through zero and wraps to the top of the range
      repeat (5) send_tick(tms_pkg::REQ_SWEEP, 3'd0, 10'd4);
      send_tick(tms_pkg::REQ_SWEEP, 3'd0, 10'd10);
      repeat (3) send_tick(REQ_IDLE, 3'd0, 10'd10);
      send_tick(REQ_IDLE, 3'd0, 10'd0);
   endtask

   task automatic test_backpressure();
      drain_block();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_stall_cycles = 300;
      repeat (30) random_tick();
   endtask

   task automatic test_random_phases();
      int hold_set [8]  = '{0, 1, 3, 16, 2, 255, 0, 5};
      int start_set [8] = '{250, 1, 1023, 250, 100, 500, 1023, 121};
      logic [1:0] pad;
      for (int ph = 0; ph < 8; ph++) begin
         drain_block();
         if (ph < 3) begin
            send_idle_pct = 23;
            rsp_idle_pct  = 70;
         end else if (ph < 6) begin
            send_idle_pct = 70;
            rsp_idle_pct  = 23;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         pad = 2'($urandom_range(3));
         write_reg(tms_pkg::CSR_NOTE_HOLD, {pad, 8'(hold_set[ph])});
         write_reg(tms_pkg::CSR_SWEEP_START, 10'(start_set[ph]));
         repeat (225) random_tick();
      end
   endtask

   // response side: random stalls, or a counted hold-off when requested
   always @(posedge clock) begin
      if (rsp_stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      tone_word_type due;
      if (rsp_tvalid && rsp_tready) begin
         if (tone_words_due.size() == 0) begin
            flag_mismatch("unexpected word", 16'h0, rsp_tdata);
         end else begin
            due = tone_words_due.pop_front();
            if (rsp_tdata[7:0] !== due.tone)
               flag_mismatch("tone_compare", 16'(due.tone), 16'(rsp_tdata[7:0]));
            if (rsp_tdata[9:8] !== due.mode)
               flag_mismatch("mode", 16'(due.mode), 16'(rsp_tdata[9:8]));
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      send_idle_pct = 23;
      rsp_idle_pct  = 70;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_wait_codes();
      test_melody_end();
      test_sweep_after_silence();
      test_freq_wrap();
      test_backpressure();
      test_random_phases();
      drain_block();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tms_pkg.sv
hw/rtl/tms_divider.sv
hw/rtl/tms_sequencer.sv
hw/rtl/tone_melody_sweep_sequencer_core.sv
verif/tb_top.sv
